// ----- design/kcp_pkg.sv -----
// Shared types, constants and the parameter count table of the keyer host command parser.
// Depends on nothing; every other file of the block imports it.
package kcp_pkg;

  localparam int FIFO_DEPTH  = 128;
  localparam int PTR_W       = $clog2(FIFO_DEPTH);
  localparam int CNT_W       = $clog2(FIFO_DEPTH + 1);
  localparam int PARAM_SLOTS = 16;
  localparam int PIDX_W      = 4;
  localparam int KEPT_W      = 5;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);
  localparam int CFG_IDX_W   = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_XOFF_THR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_XON_THR  = 1'd1;

  localparam logic [7:0] ST_READY    = 8'hC0;
  localparam logic [7:0] ST_BUFFERED = 8'hC4;
  localparam logic [7:0] ST_XON      = 8'hC4;
  localparam logic [7:0] ST_XOFF     = 8'hC5;
  localparam logic [7:0] ST_BREAKIN  = 8'hC6;

  localparam logic [5:0] CMD_CLEAR_BUF = 6'h0A;
  localparam logic [5:0] CMD_MODE_A    = 6'h0E;
  localparam logic [5:0] CMD_MODE_B    = 6'h0F;
  localparam logic [5:0] CMD_BUF_PTR   = 6'h16;
  localparam logic [5:0] ADMIN_BASE    = 6'h20;
  localparam logic [7:0] ADMIN_MAX_OFS = 8'h0D;
  localparam logic [7:0] CMD_LIMIT     = 8'h20;
  localparam logic [7:0] LONG_COUNT    = 8'd255;

  typedef enum logic [1:0] {
    REQ_HOST  = 2'd0,
    REQ_PULL  = 2'd1,
    REQ_BREAK = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    K_TX      = 3'd0,
    K_CHAR    = 3'd1,
    K_PARAM   = 3'd2,
    K_DONE    = 3'd3,
    K_REFUSED = 3'd4,
    K_EMPTY   = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    OP_TEXT  = 3'd0,
    OP_PULL  = 3'd1,
    OP_BREAK = 3'd2,
    OP_PARAM = 3'd3,
    OP_DONE  = 3'd4
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [7:0]        data;
    logic [PIDX_W-1:0] pidx;
    logic              store;
    logic [KEPT_W-1:0] kept;
    logic [5:0]        cmd;
  } op_t;

  typedef struct packed {
    logic [7:0] xoff_thr;
    logic [7:0] xon_thr;
  } cfg_t;

  // Parameter bytes that follow each command code.
  function automatic logic [7:0] param_count(input logic [5:0] code);
    logic [7:0] cnt;
    case (code)
      6'd1, 6'd2, 6'd3, 6'd6, 6'd9, 6'd11, 6'd12, 6'd13, 6'd14, 6'd16, 6'd17, 6'd18,
      6'd20, 6'd22, 6'd23, 6'd24, 6'd25, 6'd26, 6'd28, 6'd29, 6'd36, 6'd45: cnt = 8'd1;
      6'd4, 6'd27: cnt = 8'd2;
      6'd5, 6'd32: cnt = 8'd3;
      6'd15:       cnt = 8'd15;
      6'd44:       cnt = 8'd255;
      default:     cnt = 8'd0;
    endcase
    return cnt;
  endfunction

endpackage

// ----- design/kcp_in_if.sv -----
// Input channel of the keyer host command parser: valid/ready and the request payload.
// Depends on kcp_pkg.
interface kcp_in_if;
  import kcp_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] host_byte;

  modport source (output valid, output req_type, output host_byte, input ready);
  modport sink (input valid, input req_type, input host_byte, output ready);
endinterface

// ----- design/kcp_out_if.sv -----
// Result channel of the keyer host command parser: valid/ready and the result payload.
// Depends on kcp_pkg.
interface kcp_out_if;
  import kcp_pkg::*;
  logic              valid;
  logic              ready;
  logic [2:0]        kind;
  logic [7:0]        value;
  logic [PIDX_W-1:0] param_index;
  logic              last;

  modport source (output valid, output kind, output value, output param_index, output last,
                  input ready);
  modport sink (input valid, input kind, input value, input param_index, input last,
                output ready);
endinterface

// ----- design/kcp_front.sv -----
// Front end: accepts requests, tracks the command parse and turns most requests into an operation.
// Depends on kcp_pkg and kcp_in_if.
module kcp_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  kcp_in_if.sink        in_ch,
  input  logic          q_full_i,
  output logic          push_o,
  output kcp_pkg::op_t  op_o
);
  import kcp_pkg::*;

  typedef enum logic [2:0] {
    PH_FETCH  = 3'b001,
    PH_ADMIN  = 3'b010,
    PH_PARAMS = 3'b100
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [5:0] cmd_q, cmd_d;
  logic [8:0] left_q, left_d;
  logic [8:0] taken_q, taken_d;

  logic       accept;
  logic       push_c;
  logic       do_start;
  logic [5:0] start_cmd;
  logic [8:0] start_cnt;
  logic [8:0] taken_new;
  logic [8:0] left_new;
  logic [7:0] b;
  logic [7:0] tab_cnt;

  assign in_ch.ready = !q_full_i;
  assign accept      = in_ch.valid && in_ch.ready;
  assign push_o      = accept && push_c;
  assign b           = in_ch.host_byte;

  always_comb begin
    phase_d   = phase_q;
    cmd_d     = cmd_q;
    left_d    = left_q;
    taken_d   = taken_q;
    push_c    = 1'b0;
    do_start  = 1'b0;
    start_cmd = '0;
    start_cnt = '0;
    tab_cnt   = '0;
    taken_new = taken_q + 9'd1;
    left_new  = left_q - 9'd1;
    op_o      = '{op: OP_TEXT, data: b, pidx: '0, store: 1'b0, kept: '0, cmd: '0};

    case (in_ch.req_type)
      REQ_HOST: begin
        case (phase_q)
          PH_ADMIN: begin
            phase_d = PH_FETCH;
            if (b <= ADMIN_MAX_OFS) begin
              do_start  = 1'b1;
              start_cmd = ADMIN_BASE + b[5:0];
              start_cnt = {1'b0, param_count(start_cmd)};
            end
          end
          PH_PARAMS: begin
            // The buffer pointer command with sub-command 3 takes one extra byte.
            if (cmd_q == CMD_BUF_PTR && taken_new == 9'd1 && b == 8'd3) begin
              left_new = left_q;
            end
            taken_d   = taken_new;
            left_d    = left_new;
            op_o.pidx = taken_q[PIDX_W-1:0];
            op_o.store = (taken_q < 9'(PARAM_SLOTS));
            op_o.cmd  = cmd_q;
            op_o.kept = (taken_new >= 9'(PARAM_SLOTS)) ? KEPT_W'(PARAM_SLOTS)
                                                      : taken_new[KEPT_W-1:0];
            if (left_new == 9'd0) begin
              op_o.op = OP_DONE;
              push_c  = 1'b1;
              phase_d = PH_FETCH;
            end else begin
              op_o.op = OP_PARAM;
              push_c  = op_o.store;
            end
          end
          default: begin
            phase_d = PH_FETCH;
            if (b == 8'd0) begin
              phase_d = PH_ADMIN;
            end else if (b < CMD_LIMIT) begin
              do_start  = 1'b1;
              start_cmd = b[5:0];
              tab_cnt   = param_count(b[5:0]);
              start_cnt = (tab_cnt == LONG_COUNT) ? 9'd256 : {1'b0, tab_cnt};
            end else begin
              op_o.op = OP_TEXT;
              push_c  = 1'b1;
            end
          end
        endcase
      end
      REQ_PULL: begin
        op_o.op = OP_PULL;
        push_c  = 1'b1;
      end
      REQ_BREAK: begin
        op_o.op = OP_BREAK;
        push_c  = 1'b1;
      end
      default: ;
    endcase

    if (do_start) begin
      cmd_d   = start_cmd;
      left_d  = start_cnt;
      taken_d = '0;
      if (start_cnt != 9'd0) begin
        phase_d = PH_PARAMS;
      end else begin
        // A command without parameters completes at once and clears slot zero.
        op_o    = '{op: OP_DONE, data: 8'd0, pidx: '0, store: 1'b1, kept: '0, cmd: start_cmd};
        push_c  = 1'b1;
        phase_d = PH_FETCH;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FETCH;
      cmd_q   <= '0;
      left_q  <= '0;
      taken_q <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      cmd_q   <= cmd_d;
      left_q  <= left_d;
      taken_q <= taken_d;
    end
  end

endmodule

// ----- design/kcp_op_queue.sv -----
// Short operation queue between the front end and the back end.
// Depends on kcp_pkg.
module kcp_op_queue (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  kcp_pkg::op_t op_i,
  input  logic         pop_i,
  output kcp_pkg::op_t head_o,
  output logic         full_o,
  output logic         empty_o
);
  import kcp_pkg::*;

  op_t               slot_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;

  assign head_o  = slot_q[rd_q];
  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign empty_o = (cnt_q == '0);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ----- design/kcp_back.sv -----
// Back end: runs queued operations on the text FIFO, status and parameter store, and emits results.
// Depends on kcp_pkg and kcp_out_if.
module kcp_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  kcp_pkg::op_t  head_i,
  input  logic          q_empty_i,
  output logic          pop_o,
  input  kcp_pkg::cfg_t cfg_i,
  kcp_out_if.source     out_ch
);
  import kcp_pkg::*;

  localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(FIFO_DEPTH);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_TEXT  = 6'b000010,
    S_PULL  = 6'b000100,
    S_BREAK = 6'b001000,
    S_DONE  = 6'b010000,
    S_STAT  = 6'b100000
  } state_e;

  state_e            state_q, state_d;
  op_t               op_q, op_d;
  logic [KEPT_W-1:0] pcnt_q, pcnt_d;
  logic [7:0]        stat_q, stat_d;
  logic [7:0]        last_st_q, last_st_d;
  logic              xoff_q, xoff_d;
  logic              echo_q, echo_d;
  logic [PTR_W-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNT_W-1:0]  fcnt_q, fcnt_d;

  logic [7:0]        fifo_mem [FIFO_DEPTH];
  logic [7:0]        rd_data_q;
  logic [7:0]        pstore_q [PARAM_SLOTS];

  logic              ovalid_q;
  kind_e             okind_q, res_kind;
  logic [7:0]        ovalue_q, res_value;
  logic [PIDX_W-1:0] opidx_q, res_pidx;
  logic              olast_q, res_last;

  logic              can_load, load, mem_we, pwe;
  logic              st_new, xoff_hit;
  logic [CNT_W-1:0]  cnt_up, cnt_dn;
  logic [7:0]        st_pick;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign can_load          = !ovalid_q || out_ch.ready;
  assign out_ch.valid       = ovalid_q;
  assign out_ch.kind        = okind_q;
  assign out_ch.value       = ovalue_q;
  assign out_ch.param_index = opidx_q;
  assign out_ch.last        = olast_q;
  assign cnt_up             = fcnt_q + 1'b1;
  assign cnt_dn             = fcnt_q - 1'b1;

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    pcnt_d    = pcnt_q;
    stat_d    = stat_q;
    last_st_d = last_st_q;
    xoff_d    = xoff_q;
    echo_d    = echo_q;
    wptr_d    = wptr_q;
    rptr_d    = rptr_q;
    fcnt_d    = fcnt_q;
    pop_o     = 1'b0;
    pwe       = 1'b0;
    mem_we    = 1'b0;
    load      = 1'b0;
    res_kind  = K_TX;
    res_value = '0;
    res_pidx  = '0;
    res_last  = 1'b0;
    st_new    = 1'b0;
    xoff_hit  = 1'b0;
    st_pick   = ST_BUFFERED;

    case (state_q)
      S_IDLE: begin
        if (!q_empty_i) begin
          pop_o = 1'b1;
          op_d  = head_i;
          pwe   = (head_i.op == OP_PARAM || head_i.op == OP_DONE) && head_i.store;
          case (head_i.op)
            OP_TEXT:  state_d = S_TEXT;
            OP_PULL:  state_d = S_PULL;
            OP_BREAK: state_d = S_BREAK;
            OP_DONE: begin
              state_d = S_DONE;
              pcnt_d  = '0;
            end
            default:  state_d = S_IDLE;
          endcase
        end
      end
      S_TEXT: begin
        if (can_load) begin
          state_d = S_IDLE;
          if (fcnt_q == DEPTH_C) begin
            load      = 1'b1;
            res_kind  = K_REFUSED;
            res_value = op_q.data;
            res_last  = 1'b1;
          end else begin
            mem_we   = 1'b1;
            wptr_d   = ptr_inc(wptr_q);
            fcnt_d   = cnt_up;
            xoff_hit = CMP_W'(DEPTH_C - cnt_up) <= CMP_W'(cfg_i.xoff_thr);
            st_new   = xoff_hit && (last_st_q != ST_XOFF);
            stat_d   = ST_XOFF;
            if (xoff_hit) begin
              xoff_d    = 1'b1;
              last_st_d = ST_XOFF;
            end
            if (echo_q) begin
              load      = 1'b1;
              res_value = op_q.data;
              res_last  = !st_new;
              if (st_new) begin
                state_d = S_STAT;
              end
            end else if (st_new) begin
              load      = 1'b1;
              res_value = ST_XOFF;
              res_last  = 1'b1;
            end
          end
        end
      end
      S_PULL: begin
        if (can_load) begin
          state_d = S_IDLE;
          load    = 1'b1;
          if (fcnt_q == '0) begin
            res_kind = K_EMPTY;
            res_last = 1'b1;
          end else begin
            res_kind = K_CHAR;
            res_value = rd_data_q;
            rptr_d   = ptr_inc(rptr_q);
            fcnt_d   = cnt_dn;
            if (cnt_dn == '0) begin
              st_pick = ST_READY;
              xoff_d  = 1'b0;
            end else if (xoff_q && (CMP_W'(DEPTH_C - cnt_dn) > CMP_W'(cfg_i.xon_thr))) begin
              st_pick = ST_XON;
              xoff_d  = 1'b0;
            end
            st_new    = (st_pick != last_st_q);
            res_last  = !st_new;
            last_st_d = st_pick;
            stat_d    = st_pick;
            if (st_new) begin
              state_d = S_STAT;
            end
          end
        end
      end
      S_BREAK: begin
        if (can_load) begin
          load      = 1'b1;
          wptr_d    = '0;
          rptr_d    = '0;
          fcnt_d    = '0;
          xoff_d    = 1'b0;
          last_st_d = ST_READY;
          // READY always differs from the status before it, so it is always sent.
          if (last_st_q != ST_BREAKIN) begin
            res_value = ST_BREAKIN;
            stat_d    = ST_READY;
            state_d   = S_STAT;
          end else begin
            res_value = ST_READY;
            res_last  = 1'b1;
            state_d   = S_IDLE;
          end
        end
      end
      S_DONE: begin
        if (can_load) begin
          load = 1'b1;
          if (pcnt_q < op_q.kept) begin
            res_kind  = K_PARAM;
            res_value = pstore_q[pcnt_q[PIDX_W-1:0]];
            res_pidx  = pcnt_q[PIDX_W-1:0];
            pcnt_d    = pcnt_q + 1'b1;
          end else begin
            res_kind  = K_DONE;
            res_value = {2'b00, op_q.cmd};
            res_last  = 1'b1;
            state_d   = S_IDLE;
            if (op_q.cmd == CMD_CLEAR_BUF) begin
              wptr_d = '0;
              rptr_d = '0;
              fcnt_d = '0;
            end else if (op_q.cmd == CMD_MODE_A || op_q.cmd == CMD_MODE_B) begin
              echo_d = pstore_q[0][2];
            end
          end
        end
      end
      S_STAT: begin
        if (can_load) begin
          load      = 1'b1;
          res_value = stat_q;
          res_last  = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      fifo_mem[wptr_q] <= op_q.data;
    end
    rd_data_q <= fifo_mem[rptr_q];
    if (pwe) begin
      pstore_q[head_i.pidx] <= head_i.data;
    end
    op_q <= op_d;
    stat_q <= stat_d;
    if (load) begin
      okind_q  <= res_kind;
      ovalue_q <= res_value;
      opidx_q  <= res_pidx;
      olast_q  <= res_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      pcnt_q    <= '0;
      last_st_q <= '0;
      xoff_q    <= 1'b0;
      echo_q    <= 1'b0;
      wptr_q    <= '0;
      rptr_q    <= '0;
      fcnt_q    <= '0;
      ovalid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      pcnt_q    <= pcnt_d;
      last_st_q <= last_st_d;
      xoff_q    <= xoff_d;
      echo_q    <= echo_d;
      wptr_q    <= wptr_d;
      rptr_q    <= rptr_d;
      fcnt_q    <= fcnt_d;
      ovalid_q  <= load || (ovalid_q && !out_ch.ready);
    end
  end

endmodule

// ----- design/keyer_host_command_parser.sv -----
// Keyer host command parser: top level joining front end, operation queue and back end.
// Depends on kcp_pkg, kcp_in_if, kcp_out_if, kcp_front, kcp_op_queue and kcp_back.
//
// The parser takes host bytes, keyer pull requests and paddle break-in events on the input
// channel and returns result items on the output channel, the final item of each request
// marked by last. The front end classifies a request in the cycle of its transfer and
// places at most one operation in a four-entry queue; the back end takes one operation
// per visit to its idle state and emits its results one per cycle while the output
// register drains. Requests that queue nothing (the admin prefix, a dropped admin code, a
// parameter past the sixteenth) touch only the front end; a kept parameter that does
// not complete its command produces nothing but still takes a back-end dispatch to
// reach the parameter store.
// The back-end sequencer, which handles one operation at a time, sets the sustained rate.
// The text FIFO has one write and one registered read port; its contents are undefined
// until written and no clearing pass is needed, as the fill count guards every read.
// Configuration writes take effect at once and are intended while the parser is idle.
module keyer_host_command_parser (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  kcp_in_if.sink                            in_ch,
  kcp_out_if.source                         out_ch,
  input  logic                              cfg_we_i,
  input  logic [kcp_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [7:0]                        cfg_wdata_i
);
  import kcp_pkg::*;

  // Threshold registers; both are compared against the free FIFO entries.
  cfg_t cfg_q;

  // Queue between the two halves: the front end pushes, the back end pops.
  op_t  push_op;
  op_t  head_op;
  logic push;
  logic pop;
  logic q_full;
  logic q_empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.xoff_thr <= 8'd4;
      cfg_q.xon_thr  <= 8'd16;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_XOFF_THR: cfg_q.xoff_thr <= cfg_wdata_i;
        CFG_XON_THR:  cfg_q.xon_thr  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // The front end accepts a transfer whenever the queue has room.
  kcp_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_ch    (in_ch),
    .q_full_i (q_full),
    .push_o   (push),
    .op_o     (push_op)
  );

  kcp_op_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (push_op),
    .pop_i   (pop),
    .head_o  (head_op),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // The back end owns the text FIFO, status tracking, echo mode and the parameter store.
  kcp_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .head_i    (head_op),
    .q_empty_i (q_empty),
    .pop_o     (pop),
    .cfg_i     (cfg_q),
    .out_ch    (out_ch)
  );

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for the keyer host command parser: directed and random requests,
// with results predicted in step with every accepted request and checked in order.
// Depends on kcp_pkg, kcp_in_if, kcp_out_if and keyer_host_command_parser.
module tb_top;
  import kcp_pkg::*;

  // The run is stopped well beyond the slowest correct run. The slowest case is a full
  // command of sixteen results with the receiver at its highest stall rate.
  localparam int CYCLE_LIMIT  = 1_000_000;
  // Cycles allowed after the last result for requests that cause none to work through.
  localparam int SETTLE_CYCLES = 40;

  localparam logic [1:0] REQ_UNDEFINED  = 2'd3;
  localparam logic [7:0] ADMIN_PREFIX   = 8'h00;
  localparam logic [7:0] PTR_MODE_EXTRA = 8'd3;
  localparam int         LONG_ADMIN     = 'h2C;

  // Where the predicted parser stands between host bytes.
  typedef enum logic [1:0] {
    AWAIT_ANY,
    AWAIT_ADMIN,
    AWAIT_PARAMS
  } parse_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] value;
    logic [3:0] pidx;
    logic       last;
  } result_t;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [7:0] cfg_wdata_i;

  kcp_in_if  req_ch ();
  kcp_out_if res_ch ();

  keyer_host_command_parser u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (req_ch),
    .out_ch      (res_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Predicted state of the parser, kept in step with every accepted request.
  parse_e     phase;
  logic [5:0] cmd_code;
  int         params_left;
  int         params_taken;
  logic [7:0] kept_params [PARAM_SLOTS];
  logic [7:0] text_q [$];
  logic [7:0] last_status;
  logic       xoff_on;
  logic       echo_en;
  logic [7:0] xoff_thr;
  logic [7:0] xon_thr;

  // Results caused by the request in hand, and results awaiting their transfer.
  result_t step_out [$];
  result_t pending_results [$];

  int send_idle_pct;
  int recv_stall_pct;
  int requests_sent;
  int results_seen;
  int mismatches;
  int cycle_count;

  // ---------------------------------------------------------------------------------------
  // Clock, watchdog and receiver
  // ---------------------------------------------------------------------------------------

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // A run that hangs, for instance because a result never arrives, ends here as a failure.
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.", cycle_count,
               pending_results.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // The receiver withholds ready at random, so that stalls can land on any result of a burst.
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------------------

  // Parameter bytes that follow each command code; codes from 0x20 are admin commands.
  function automatic int code_param_count(input int code);
    case (code)
      0, 7, 8, 10, 19, 21, 30, 31, 33, 34, 35,
      37, 38, 39, 40, 41, 42, 43: return 0;
      4, 27:                      return 2;
      5, 32:                      return 3;
      15:                         return 15;
      LONG_ADMIN:                 return 255;
      default:                    return 1;
    endcase
  endfunction

  function automatic void add_result(input kind_e k, input logic [7:0] v,
                                     input logic [3:0] idx);
    result_t r;
    r.kind  = k;
    r.value = v;
    r.pidx  = idx;
    r.last  = 1'b0;
    step_out.push_back(r);
  endfunction

  // A status byte goes to the host only when it differs from the one sent before.
  function automatic void post_status(input logic [7:0] st);
    if (st != last_status) add_result(K_TX, st, 4'd0);
    last_status = st;
  endfunction

  // A finished command reports its kept parameters and then its code; only clear-buffer
  // and the two mode commands (echo from bit 2 of the first parameter) take effect.
  function automatic void finish_command();
    int n;
    n = (params_taken < PARAM_SLOTS) ? params_taken : PARAM_SLOTS;
    for (int i = 0; i < n; i++) add_result(K_PARAM, kept_params[i], 4'(i));
    add_result(K_DONE, {2'b00, cmd_code}, 4'd0);
    if (cmd_code == CMD_CLEAR_BUF) text_q.delete();
    else if (cmd_code == CMD_MODE_A || cmd_code == CMD_MODE_B) echo_en = kept_params[0][2];
    phase = AWAIT_ANY;
  endfunction

  function automatic void open_command(input int code, input int count);
    cmd_code     = 6'(code);
    params_left  = count;
    params_taken = 0;
    if (count > 0) begin
      phase = AWAIT_PARAMS;
    end else begin
      kept_params[0] = 8'h00;
      finish_command();
    end
  endfunction

  function automatic void take_host_byte(input logic [7:0] hb);
    int cnt;
    case (phase)
      AWAIT_ADMIN: begin
        if (hb > ADMIN_MAX_OFS) phase = AWAIT_ANY;
        else open_command(ADMIN_BASE + hb, code_param_count(ADMIN_BASE + hb));
      end
      AWAIT_PARAMS: begin
        if (params_left > 0) begin
          if (params_taken < PARAM_SLOTS) kept_params[params_taken] = hb;
          params_taken = (params_taken + 1) & 'h1FF;
          if (cmd_code == CMD_BUF_PTR && params_taken == 1 && hb == PTR_MODE_EXTRA)
            params_left++;
          params_left--;
        end
        if (params_left == 0) finish_command();
      end
      default: begin
        phase = AWAIT_ANY;
        if (hb == ADMIN_PREFIX) begin
          phase = AWAIT_ADMIN;
        end else if (hb < CMD_LIMIT) begin
          cnt = code_param_count(hb);
          open_command(hb, (cnt == LONG_COUNT) ? 256 : cnt);
        end else if (text_q.size() >= FIFO_DEPTH) begin
          add_result(K_REFUSED, hb, 4'd0);
        end else begin
          text_q.push_back(hb);
          if (echo_en) add_result(K_TX, hb, 4'd0);
          if (FIFO_DEPTH - text_q.size() <= xoff_thr) begin
            xoff_on = 1'b1;
            post_status(ST_XOFF);
          end
        end
      end
    endcase
  endfunction

  function automatic void pull_text();
    logic [7:0] c;
    if (text_q.size() == 0) begin
      add_result(K_EMPTY, 8'h00, 4'd0);
      return;
    end
    c = text_q.pop_front();
    add_result(K_CHAR, c, 4'd0);
    if (text_q.size() == 0) begin
      xoff_on = 1'b0;
      post_status(ST_READY);
    end else if (xoff_on && (FIFO_DEPTH - text_q.size() > xon_thr)) begin
      xoff_on = 1'b0;
      post_status(ST_XON);
    end else begin
      post_status(ST_BUFFERED);
    end
  endfunction

  // Works out the results of one accepted request and queues them for checking.
  function automatic void parse_request(input logic [1:0] rt, input logic [7:0] hb);
    step_out.delete();
    case (rt)
      REQ_HOST:  take_host_byte(hb);
      REQ_PULL:  pull_text();
      REQ_BREAK: begin
        text_q.delete();
        post_status(ST_BREAKIN);
        xoff_on = 1'b0;
        post_status(ST_READY);
      end
      default: ;
    endcase
    if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
    foreach (step_out[i]) pending_results.push_back(step_out[i]);
  endfunction

  function automatic void reset_prediction();
    phase        = AWAIT_ANY;
    cmd_code     = 6'd0;
    params_left  = 0;
    params_taken = 0;
    text_q.delete();
    last_status  = 8'h00;
    xoff_on      = 1'b0;
    echo_en      = 1'b0;
    xoff_thr     = 8'd4;
    xon_thr      = 8'd16;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // Each result transfer is compared with the oldest expectation still waiting.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d value %02h index %0d last %0b",
                                  res_ch.kind, res_ch.value, res_ch.param_index, res_ch.last));
      end else begin
        want = pending_results.pop_front();
        if (res_ch.kind !== want.kind || res_ch.value !== want.value ||
            res_ch.param_index !== want.pidx || res_ch.last !== want.last)
          report_mismatch($sformatf(
            "result %0d: got kind %0d value %02h index %0d last %0b, want %0d %02h %0d %0b",
            results_seen, res_ch.kind, res_ch.value, res_ch.param_index, res_ch.last,
            want.kind, want.value, want.pidx, want.last));
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------------------

  // Offers one request, with a random gap before it, and returns at the edge of its
  // transfer. Valid is left high so that the next request may follow without a gap.
  task automatic send_request(input logic [1:0] rt, input logic [7:0] hb);
    if ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    req_ch.valid     <= 1'b1;
    req_ch.req_type  <= rt;
    req_ch.host_byte <= hb;
    do @(posedge clk_i); while (req_ch.ready !== 1'b1);
    parse_request(rt, hb);
    if (rt != REQ_UNDEFINED) requests_sent++;
  endtask

  // Holds the sender back until every predicted result has been transferred, then lets
  // requests that cause no result work through before anything else happens.
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Both thresholds are written back to back; the parser is idle whenever this is called.
  task automatic write_thresholds(input logic [7:0] xoff_v, input logic [7:0] xon_v);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_XOFF_THR;
    cfg_wdata_i <= xoff_v;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_XON_THR;
    cfg_wdata_i <= xon_v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    xoff_thr = xoff_v;
    xon_thr  = xon_v;
  endtask

  // Sends a command code, with the admin prefix where needed, and its parameters with
  // random content. A buffer pointer command sometimes takes the extra parameter. When
  // cut short, the command stops early and the bytes that follow become its parameters.
  // Pulls and break-ins are sprinkled in, as they must not disturb the parse.
  task automatic send_command(input int code, input bit cut_short);
    int         total;
    int         limit;
    logic [7:0] p;
    if (code >= ADMIN_BASE) begin
      send_request(REQ_HOST, ADMIN_PREFIX);
      send_request(REQ_HOST, 8'(code - ADMIN_BASE));
    end else begin
      send_request(REQ_HOST, 8'(code));
    end
    total = code_param_count(code);
    limit = cut_short ? $urandom_range(total) : total;
    for (int i = 0; i < limit; i++) begin
      p = 8'($urandom_range(255));
      if (code == CMD_BUF_PTR && i == 0 && !cut_short && $urandom_range(1) == 1) begin
        p = PTR_MODE_EXTRA;
        limit++;
      end
      if ($urandom_range(19) == 0)
        send_request(($urandom_range(1) == 1) ? REQ_PULL : REQ_BREAK, 8'($urandom_range(255)));
      send_request(REQ_HOST, p);
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------------------

  // Field extremes, every request type, echo on and off, the buffer pointer command both
  // ways, admin codes at and beyond the limit, clear-buffer, and pulls from an empty FIFO.
  task automatic test_directed();
    send_request(REQ_UNDEFINED, 8'hFF);
    send_request(REQ_PULL, 8'h00);
    send_request(REQ_HOST, CMD_LIMIT);
    send_request(REQ_HOST, 8'hFF);
    send_request(REQ_PULL, 8'hFF);
    send_request(REQ_PULL, 8'h00);
    send_request(REQ_HOST, 8'h01);
    send_request(REQ_HOST, 8'h00);
    send_request(REQ_HOST, 8'h1F);
    send_request(REQ_HOST, 8'(CMD_MODE_A));
    send_request(REQ_HOST, 8'h04);
    send_request(REQ_HOST, 8'h41);
    send_request(REQ_HOST, 8'(CMD_MODE_B));
    for (int i = 0; i < 15; i++) send_request(REQ_HOST, 8'hFB);
    send_request(REQ_HOST, 8'(CMD_BUF_PTR));
    send_request(REQ_HOST, PTR_MODE_EXTRA);
    send_request(REQ_HOST, 8'h55);
    send_request(REQ_HOST, 8'(CMD_BUF_PTR));
    send_request(REQ_HOST, 8'h02);
    send_request(REQ_HOST, ADMIN_PREFIX);
    send_request(REQ_HOST, ADMIN_MAX_OFS + 8'd1);
    send_request(REQ_HOST, ADMIN_PREFIX);
    send_request(REQ_HOST, ADMIN_MAX_OFS);
    send_request(REQ_HOST, 8'hAA);
    send_request(REQ_HOST, ADMIN_PREFIX);
    send_request(REQ_HOST, 8'hFF);
    send_request(REQ_HOST, 8'(CMD_CLEAR_BUF));
    send_request(REQ_PULL, 8'h00);
    send_request(REQ_BREAK, 8'h00);
  endtask

  // Fills the text FIFO past full, so that bytes are refused and XOFF is raised, pulls a
  // few characters so that the status moves on from XOFF, and empties it by a break-in.
  task automatic test_fifo_flow();
    send_request(REQ_BREAK, 8'($urandom_range(255)));
    repeat (FIFO_DEPTH + 2) send_request(REQ_HOST, 8'($urandom_range(255, CMD_LIMIT)));
    repeat (FIFO_DEPTH / 8) send_request(REQ_PULL, 8'($urandom_range(255)));
    send_request(REQ_BREAK, 8'($urandom_range(255)));
  endtask

  // The longest regular command keeps all fifteen of its parameters, the largest burst of
  // results that the run asks for.
  task automatic test_long_commands();
    send_command(CMD_MODE_B, 1'b0);
  endtask

  // Mostly well-formed traffic with random content, with truncated commands and raw noise
  // mixed in. Now and then the sender waits for every outstanding result.
  task automatic test_random(input int n_req);
    int goal;
    int pick;
    int code;
    goal = requests_sent + n_req;
    while (requests_sent < goal) begin
      pick = $urandom_range(99);
      if (pick < 25) begin
        repeat ($urandom_range(5, 1))
          send_request(REQ_HOST, 8'($urandom_range(255, CMD_LIMIT)));
      end else if (pick < 45) begin
        repeat ($urandom_range(5, 1)) send_request(REQ_PULL, 8'($urandom_range(255)));
      end else if (pick < 65) begin
        send_command($urandom_range(31, 1), 1'b0);
      end else if (pick < 72) begin
        code = ADMIN_BASE + $urandom_range(ADMIN_MAX_OFS);
        if (code == LONG_ADMIN) code = ADMIN_BASE;
        send_command(code, 1'b0);
      end else if (pick < 77) begin
        send_request(REQ_BREAK, 8'($urandom_range(255)));
      end else if (pick < 87) begin
        send_command($urandom_range(31, 1), 1'b1);
      end else begin
        send_request(2'($urandom_range(3)), 8'($urandom_range(255)));
      end
      if ($urandom_range(39) == 0) drain_results();
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Sequence of the run
  // ---------------------------------------------------------------------------------------

  initial begin
    requests_sent    = 0;
    results_seen     = 0;
    mismatches       = 0;
    send_idle_pct    = 15;
    recv_stall_pct   = 76;
    req_ch.valid     <= 1'b0;
    req_ch.req_type  <= REQ_HOST;
    req_ch.host_byte <= 8'h00;
    cfg_we_i         <= 1'b0;
    cfg_idx_i        <= CFG_XOFF_THR;
    cfg_wdata_i      <= 8'h00;
    rst_ni           <= 1'b0;
    reset_prediction();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Busy sender, hesitant receiver: results pile up behind the back end.
    write_thresholds(8'd10, 8'd40);
    test_directed();
    test_fifo_flow();
    drain_results();

    // Hesitant sender, sparse receiver stalls, XOFF on every push and XON on a later pull.
    send_idle_pct  = 76;
    recv_stall_pct = 15;
    write_thresholds(8'd128, 8'd0);
    test_long_commands();
    test_random(20);
    drain_results();

    // No idling at all: XOFF only on a full FIFO and XON never chosen.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_thresholds(8'd0, 8'd128);
    test_random(20);
    drain_results();

    write_thresholds(8'($urandom_range(128)), 8'($urandom_range(128)));
    test_random(15);
    drain_results();

    $display("Checked %0d results from %0d requests across three idling patterns.",
             results_seen, requests_sent);
    $display("Thresholds ranged from 0 to 128; %0d mismatches were found.", mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
